[hw/rtl/fjt_pkg.sv]
// shared types, codes and character helpers for the flat json tokenizer
`timescale 1ns / 1ps
`default_nettype none
package fjt_pkg;

	typedef enum logic [3:0] {
		ST_OPEN  = 4'd0,
		ST_SKEY  = 4'd1,
		ST_KEY   = 4'd2,
		ST_COLON = 4'd3,
		ST_SVAL  = 4'd4,
		ST_STR   = 4'd5,
		ST_NUM   = 4'd6,
		ST_COMMA = 4'd7,
		ST_DONE  = 4'd8,
		ST_ERR   = 4'd9
	} stage_t;

	typedef enum logic [2:0] {
		K_KEY    = 3'd0,
		K_STR    = 3'd1,
		K_NUM    = 3'd2,
		K_PAIR   = 3'd3,
		K_ACCEPT = 3'd4,
		K_REJECT = 3'd5
	} kind_t;

	// work left for the back end by one item
	typedef struct packed {
		logic       has_tok;
		kind_t      tok_kind;
		logic [7:0] tok_ch;
		logic       tok_is_num;
		logic       has_verdict;
		logic       verdict_ok;
	} cmd_t;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam logic [QAW:0] QFULL = (QAW + 1)'(QDEPTH);

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/flat_json_object_tokenizer_core.sv]
// top level of the flat json object tokenizer
`timescale 1ns / 1ps
`default_nettype none
// Takes one character per cycle while full is low, through a push/full queue interface, and hands
// out key, string and number characters, pair-complete marks and an accept or reject verdict
// through an empty/pop queue interface. The syntax state machine decides each character
// combinationally as it is taken, so a new item is taken every clock while the 4-entry command
// queue has room; an item that both carries a token and ends the text yields two results, which
// the output side delivers one after the other from its output register. A pushed item passes
// through the command queue and the output register before its first result shows.
module flat_json_object_tokenizer_core
	import fjt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] ch,
	input  wire logic       end_of_text,
	output logic            empty,
	input  wire logic       pop,
	output logic [2:0]      kind,
	output logic [7:0]      ch_out,
	output logic            pair_is_number,
	output logic            last
);

	cmd_t wr_cmd;
	cmd_t rd_cmd;
	logic q_push;
	logic q_pop;
	logic q_empty;

	fjt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.ch          (ch),
		.end_of_text (end_of_text),
		.q_full      (full),
		.q_push      (q_push),
		.q_data      (wr_cmd)
	);

	fjt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (wr_cmd),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (rd_cmd),
		.empty   (q_empty)
	);

	fjt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_data         (rd_cmd),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.kind           (kind),
		.ch_out         (ch_out),
		.pair_is_number (pair_is_number),
		.last           (last)
	);

endmodule
`default_nettype wire

[hw/rtl/fjt_front.sv]
// front end: syntax state machine; items with a token or a verdict become commands
`timescale 1ns / 1ps
`default_nettype none
module fjt_front
	import fjt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] ch,
	input  wire logic       end_of_text,
	input  wire logic       q_full,
	output logic            q_push,
	output cmd_t            q_data
);

	stage_t stage_q, stage_d, stage_p;
	logic   key_nonempty_q, key_nonempty_d;
	logic   prev_backslash_q, prev_backslash_d;
	logic   number_has_dot_q, number_has_dot_d;
	logic   number_has_digit_q, number_has_digit_d;
	logic   accept;
	logic   tok_valid;
	kind_t  tok_kind;
	logic [7:0] tok_ch;
	logic   tok_is_num;

	assign accept = push && !q_full;

	// next state
	always_comb begin
		stage_p            = stage_q;
		key_nonempty_d     = key_nonempty_q;
		prev_backslash_d   = prev_backslash_q;
		number_has_dot_d   = number_has_dot_q;
		number_has_digit_d = number_has_digit_q;
		unique case (stage_q)
			ST_OPEN: begin
				if (is_ws(ch)) stage_p = ST_OPEN;
				else if (ch == CH_LBRACE) stage_p = ST_SKEY;
				else stage_p = ST_ERR;
			end
			ST_SKEY: begin
				if (is_ws(ch)) stage_p = ST_SKEY;
				else if (ch == CH_QUOTE) begin
					key_nonempty_d = 1'b0;
					stage_p = ST_KEY;
				end else if (ch == CH_RBRACE) stage_p = ST_DONE;
				else stage_p = ST_ERR;
			end
			ST_KEY: begin
				if (ch == CH_QUOTE) stage_p = key_nonempty_q ? ST_COLON : ST_ERR;
				else key_nonempty_d = 1'b1;
			end
			ST_COLON: begin
				if (is_ws(ch)) stage_p = ST_COLON;
				else if (ch == CH_COLON) stage_p = ST_SVAL;
				else stage_p = ST_ERR;
			end
			ST_SVAL: begin
				if (is_ws(ch)) stage_p = ST_SVAL;
				else if (ch == CH_QUOTE) begin
					prev_backslash_d = 1'b0;
					stage_p = ST_STR;
				end else if (is_digit(ch)) begin
					number_has_dot_d   = 1'b0;
					number_has_digit_d = 1'b1;
					stage_p = ST_NUM;
				end else if (ch == CH_DOT) begin
					number_has_dot_d   = 1'b1;
					number_has_digit_d = 1'b0;
					stage_p = ST_NUM;
				end else stage_p = ST_ERR;
			end
			ST_STR: begin
				if (ch == CH_QUOTE && !prev_backslash_q) stage_p = ST_COMMA;
				prev_backslash_d = (ch == CH_BSLASH);
			end
			ST_NUM: begin
				if (is_digit(ch)) number_has_digit_d = 1'b1;
				else if (ch == CH_DOT) begin
					if (number_has_dot_q) stage_p = ST_ERR;
					else number_has_dot_d = 1'b1;
				end else if (!number_has_digit_q) stage_p = ST_ERR;
				// number ends, the same char goes through the comma search
				else if (is_ws(ch)) stage_p = ST_COMMA;
				else if (ch == CH_COMMA) stage_p = ST_SKEY;
				else if (ch == CH_RBRACE) stage_p = ST_DONE;
				else stage_p = ST_ERR;
			end
			ST_COMMA: begin
				if (is_ws(ch)) stage_p = ST_COMMA;
				else if (ch == CH_COMMA) stage_p = ST_SKEY;
				else if (ch == CH_RBRACE) stage_p = ST_DONE;
				else stage_p = ST_ERR;
			end
			ST_DONE: begin
				if (!is_ws(ch)) stage_p = ST_ERR;
			end
			default: stage_p = ST_ERR;
		endcase
		stage_d = stage_p;
		if (end_of_text) begin
			stage_d            = ST_OPEN;
			key_nonempty_d     = 1'b0;
			prev_backslash_d   = 1'b0;
			number_has_dot_d   = 1'b0;
			number_has_digit_d = 1'b0;
		end
	end

	// token outputs
	always_comb begin
		tok_valid  = 1'b0;
		tok_kind   = K_KEY;
		tok_ch     = ch;
		tok_is_num = 1'b0;
		unique case (stage_q)
			ST_KEY: begin
				if (ch != CH_QUOTE) tok_valid = 1'b1;
			end
			ST_SVAL: begin
				if (is_digit(ch) || ch == CH_DOT) begin
					tok_valid = 1'b1;
					tok_kind  = K_NUM;
				end
			end
			ST_STR: begin
				tok_valid = 1'b1;
				if (ch == CH_QUOTE && !prev_backslash_q) begin
					tok_kind = K_PAIR;
					tok_ch   = 8'h00;
				end else tok_kind = K_STR;
			end
			ST_NUM: begin
				if (is_digit(ch) || (ch == CH_DOT && !number_has_dot_q)) begin
					tok_valid = 1'b1;
					tok_kind  = K_NUM;
				end else if (ch != CH_DOT && number_has_digit_q) begin
					tok_valid  = 1'b1;
					tok_kind   = K_PAIR;
					tok_ch     = 8'h00;
					tok_is_num = 1'b1;
				end
			end
			default: tok_valid = 1'b0;
		endcase
	end

	always_comb begin
		q_data.has_tok     = tok_valid;
		q_data.tok_kind    = tok_kind;
		q_data.tok_ch      = tok_ch;
		q_data.tok_is_num  = tok_is_num;
		q_data.has_verdict = end_of_text;
		q_data.verdict_ok  = (stage_p == ST_DONE);
	end

	assign q_push = accept && (tok_valid || end_of_text);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q            <= ST_OPEN;
			key_nonempty_q     <= 1'b0;
			prev_backslash_q   <= 1'b0;
			number_has_dot_q   <= 1'b0;
			number_has_digit_q <= 1'b0;
		end else if (accept) begin
			stage_q            <= stage_d;
			key_nonempty_q     <= key_nonempty_d;
			prev_backslash_q   <= prev_backslash_d;
			number_has_dot_q   <= number_has_dot_d;
			number_has_digit_q <= number_has_digit_d;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_text) |=> (stage_q == ST_OPEN))
		else $error("state not cleared after end of text");
`endif

endmodule
`default_nettype wire

[hw/rtl/fjt_queue.sv]
// command queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module fjt_queue
	import fjt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      empty
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = (count_q == QFULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= QFULL)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a write");
`endif

endmodule
`default_nettype wire

[hw/rtl/fjt_back.sv]
// back end: unpacks each command into one or two result items
`timescale 1ns / 1ps
`default_nettype none
module fjt_back
	import fjt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_empty,
	input  wire cmd_t  q_data,
	output logic       q_pop,
	output logic       empty,
	input  wire logic  pop,
	output logic [2:0] kind,
	output logic [7:0] ch_out,
	output logic       pair_is_number,
	output logic       last
);

	cmd_t  cur_q;
	logic  cur_valid_q;
	logic  phase_q;
	logic  show_verdict;
	logic  take;
	logic  finish;
	logic  load;
	kind_t kind_sel;

	assign show_verdict = phase_q || !cur_q.has_tok;
	assign kind_sel = show_verdict ? (cur_q.verdict_ok ? K_ACCEPT : K_REJECT) : cur_q.tok_kind;
	assign kind = kind_sel;
	assign ch_out = show_verdict ? 8'h00 : cur_q.tok_ch;
	assign pair_is_number = show_verdict ? 1'b0 : cur_q.tok_is_num;
	assign last = show_verdict || !cur_q.has_verdict;
	assign empty = !cur_valid_q;

	assign take   = cur_valid_q && pop;
	assign finish = take && last;
	assign load   = !cur_valid_q || finish;
	assign q_pop  = load && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (q_pop) cur_valid_q <= 1'b1;
			else if (finish) cur_valid_q <= 1'b0;
			if (load) phase_q <= 1'b0;
			else if (take) phase_q <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind_sel == K_ACCEPT || kind_sel == K_REJECT)) |-> last)
		else $error("verdict item not marked last");
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !(kind_sel == K_KEY || kind_sel == K_STR || kind_sel == K_NUM))
		|-> (ch_out == 8'h00))
		else $error("nonzero char on a mark item");
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (cur_valid_q && cur_q.has_tok && cur_q.has_verdict))
		else $error("second phase without a two-item command");
`endif

endmodule
`default_nettype wire

[tb/tb_flat_json_object_tokenizer_core.sv]
// testbench for the flat json object tokenizer core: directed and random texts against a predictor
`timescale 1ns / 1ps
module tb_flat_json_object_tokenizer_core;
	import fjt_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	typedef logic [7:0] text_t[$];

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       is_num;
		logic       last;
	} token_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] ch = 8'h00;
	logic       end_of_text = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [2:0] kind;
	logic [7:0] ch_out;
	logic       pair_is_number;
	logic       last;

	flat_json_object_tokenizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.ch(ch),
		.end_of_text(end_of_text),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.ch_out(ch_out),
		.pair_is_number(pair_is_number),
		.last(last)
	);

	always #2 clk = ~clk;

	// predictor state
	stage_t stg = ST_OPEN;
	bit     key_seen = 1'b0;
	bit     esc_prev = 1'b0;
	bit     num_dot = 1'b0;
	bit     num_digit = 1'b0;

	token_t pending_tokens[$];
	bit     idle_on = 1'b1;
	int     errors = 0;
	int     n_items = 0;
	int     n_texts = 0;
	int     n_results = 0;
	int     n_accept = 0;
	int     n_reject = 0;
	int     quiet = 0;

	function automatic bit blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task automatic tokenize_char(input logic [7:0] c, input logic e);
		token_t res[2];
		int     n;
		bit     again;
		n = 0;
		do begin
			again = 1'b0;
			case (stg)
				ST_OPEN: if (!blank(c)) stg = (c == CH_LBRACE) ? ST_SKEY : ST_ERR;
				ST_SKEY: begin
					if (blank(c)) begin
					end else if (c == CH_QUOTE) begin
						key_seen = 1'b0;
						stg = ST_KEY;
					end else if (c == CH_RBRACE) begin
						stg = ST_DONE;
					end else begin
						stg = ST_ERR;
					end
				end
				ST_KEY: begin
					if (c == CH_QUOTE) begin
						stg = key_seen ? ST_COLON : ST_ERR;
					end else begin
						key_seen = 1'b1;
						res[n] = '{K_KEY, c, 1'b0, 1'b0};
						n++;
					end
				end
				ST_COLON: if (!blank(c)) stg = (c == CH_COLON) ? ST_SVAL : ST_ERR;
				ST_SVAL: begin
					if (blank(c)) begin
					end else if (c == CH_QUOTE) begin
						esc_prev = 1'b0;
						stg = ST_STR;
					end else if (digit(c) || c == CH_DOT) begin
						num_dot = 1'b0;
						num_digit = 1'b0;
						stg = ST_NUM;
						again = 1'b1;
					end else begin
						stg = ST_ERR;
					end
				end
				ST_STR: begin
					if (c == CH_QUOTE && !esc_prev) begin
						res[n] = '{K_PAIR, 8'h00, 1'b0, 1'b0};
						stg = ST_COMMA;
					end else begin
						res[n] = '{K_STR, c, 1'b0, 1'b0};
					end
					n++;
					esc_prev = (c == CH_BSLASH);
				end
				ST_NUM: begin
					if (digit(c)) begin
						num_digit = 1'b1;
						res[n] = '{K_NUM, c, 1'b0, 1'b0};
						n++;
					end else if (c == CH_DOT) begin
						if (num_dot) begin
							stg = ST_ERR;
						end else begin
							num_dot = 1'b1;
							res[n] = '{K_NUM, c, 1'b0, 1'b0};
							n++;
						end
					end else if (!num_digit) begin
						stg = ST_ERR;
					end else begin
						res[n] = '{K_PAIR, 8'h00, 1'b1, 1'b0};
						n++;
						stg = ST_COMMA;
						again = 1'b1;
					end
				end
				ST_COMMA: begin
					if (blank(c)) begin
					end else if (c == CH_COMMA) begin
						stg = ST_SKEY;
					end else if (c == CH_RBRACE) begin
						stg = ST_DONE;
					end else begin
						stg = ST_ERR;
					end
				end
				ST_DONE: if (!blank(c)) stg = ST_ERR;
				default: stg = ST_ERR;
			endcase
		end while (again);
		if (e) begin
			res[n] = '{(stg == ST_DONE) ? K_ACCEPT : K_REJECT, 8'h00, 1'b0, 1'b0};
			n++;
			stg = ST_OPEN;
			key_seen = 1'b0;
			esc_prev = 1'b0;
			num_dot = 1'b0;
			num_digit = 1'b0;
		end
		if (n > 0) res[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++) pending_tokens.push_back(res[i]);
	endtask

	task automatic send_item(input logic [7:0] c, input logic e);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			ch <= 8'($urandom);
			end_of_text <= 1'($urandom);
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push <= 1'b1;
		ch <= c;
		end_of_text <= e;
		do @(posedge clk); while (full);
		tokenize_char(c, e);
		n_items++;
		if (e) n_texts++;
	endtask

	task automatic send_text(input text_t t);
		foreach (t[i]) send_item(t[i], i == t.size() - 1);
	endtask

	task automatic add_blank(ref text_t t, input int maxn);
		int k;
		k = $urandom_range(0, maxn);
		repeat (k) t.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : 8'h20);
	endtask

	function automatic logic [7:0] special_char();
		logic [7:0] set[12];
		set = '{CH_LBRACE, CH_RBRACE, "[", "]", CH_QUOTE, CH_COLON, CH_COMMA, CH_DOT,
			CH_BSLASH, "7", 8'h20, 8'($urandom)};
		return set[$urandom_range(0, 11)];
	endfunction

	task automatic make_object(ref text_t t);
		int         np;
		int         len;
		int         dotpos;
		logic [7:0] b;
		t.delete();
		add_blank(t, 2);
		t.push_back(CH_LBRACE);
		np = $urandom_range(0, 4);
		for (int p = 0; p < np; p++) begin
			add_blank(t, 2);
			t.push_back(CH_QUOTE);
			len = $urandom_range(1, 4);
			repeat (len) begin
				do b = 8'($urandom); while (b == CH_QUOTE);
				t.push_back(b);
			end
			t.push_back(CH_QUOTE);
			add_blank(t, 1);
			t.push_back(CH_COLON);
			add_blank(t, 1);
			if ($urandom_range(0, 1)) begin
				t.push_back(CH_QUOTE);
				len = $urandom_range(0, 5);
				repeat (len) begin
					if ($urandom_range(0, 5) == 0) begin
						t.push_back(CH_BSLASH);
						do b = 8'($urandom); while (b == CH_BSLASH);
					end else begin
						do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
					end
					t.push_back(b);
				end
				t.push_back(CH_QUOTE);
			end else begin
				len = $urandom_range(1, 4);
				dotpos = $urandom_range(0, len + 2);
				for (int k = 0; k <= len; k++) begin
					if (k == dotpos) t.push_back(CH_DOT);
					if (k < len) t.push_back(8'($urandom_range(48, 57)));
				end
			end
			add_blank(t, 1);
			if (p < np - 1 || $urandom_range(0, 3) == 0) begin
				t.push_back(CH_COMMA);
				add_blank(t, 1);
			end
		end
		t.push_back(CH_RBRACE);
		add_blank(t, 2);
	endtask

	task automatic make_broken(ref text_t t);
		int pos;
		make_object(t);
		pos = $urandom_range(0, t.size() - 1);
		case ($urandom_range(0, 3))
			0: t[pos] = special_char();
			1: while (t.size() > pos + 1) void'(t.pop_back());
			2: t.insert(pos, special_char());
			default: begin
				t.delete();
				repeat ($urandom_range(1, 8)) t.push_back(special_char());
			end
		endcase
	endtask

	task automatic test_directed();
		text_t t;
		// escaped quote inside a string, number opened by a dot, trailing comma, byte extremes
		t = '{8'h09, CH_LBRACE, CH_QUOTE, 8'hFF, CH_QUOTE, CH_COLON, CH_DOT, "5", CH_COMMA,
			CH_QUOTE, "k", CH_QUOTE, CH_COLON, CH_QUOTE, 8'h00, CH_BSLASH, CH_QUOTE, CH_QUOTE,
			CH_COMMA, CH_RBRACE, 8'h20};
		send_text(t);
		// number ended by the closing brace on the last character
		t = '{CH_LBRACE, CH_QUOTE, "a", CH_QUOTE, CH_COLON, "7", CH_RBRACE};
		send_text(t);
		// empty key
		t = '{CH_LBRACE, CH_QUOTE, CH_QUOTE};
		send_text(t);
	endtask

	task automatic test_wellformed_random(input int count);
		text_t t;
		int    stop;
		stop = n_items + count;
		while (n_items < stop) begin
			make_object(t);
			send_text(t);
		end
	endtask

	task automatic test_broken_random(input int count);
		text_t t;
		int    stop;
		stop = n_items + count;
		while (n_items < stop) begin
			make_broken(t);
			send_text(t);
		end
	endtask

	task automatic test_back_to_back(input int count);
		text_t t;
		int    stop;
		idle_on = 1'b0;
		stop = n_items + count;
		while (n_items < stop) begin
			if ($urandom_range(0, 3) == 0) make_broken(t);
			else make_object(t);
			send_text(t);
		end
	endtask

	// result side: random stalls while idle_on is set, and comparison of all fields at once
	initial begin
		int     stall;
		token_t got;
		token_t want;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got = '{kind_t'(kind), ch_out, pair_is_number, last};
				n_results++;
				if (got.kind == K_ACCEPT) n_accept++;
				if (got.kind == K_REJECT) n_reject++;
				if (pending_tokens.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: kind %0d ch %02h num %0b last %0b",
							kind, ch_out, pair_is_number, last);
				end else begin
					want = pending_tokens.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: expected kind %0d ch %02h num %0b last %0b, ",
								"got kind %0d ch %02h num %0b last %0b"},
								want.kind, want.ch, want.is_num, want.last,
								kind, ch_out, pair_is_number, last);
					end
				end
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				stall = $urandom_range(1, 11) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_wellformed_random(800);
		test_broken_random(350);
		test_back_to_back(250);
		push <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d characters in %0d texts, checked %0d results", n_items, n_texts,
			n_results);
		$display("verdicts: %0d accepted, %0d rejected; %0d mismatches", n_accept, n_reject,
			errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/fjt_pkg.sv
hw/rtl/fjt_front.sv
hw/rtl/fjt_queue.sv
hw/rtl/fjt_back.sv
hw/rtl/flat_json_object_tokenizer_core.sv
tb/tb_flat_json_object_tokenizer_core.sv
